FILE: hw/rtl/float32_adder_top_assert.svh
// Assertion macros shared by the float32 adder RTL.
// Depends on nothing; included inside module bodies.
`ifndef FLOAT32_ADDER_TOP_ASSERT_SVH
`define FLOAT32_ADDER_TOP_ASSERT_SVH

// Checks that a consequent holds in the same cycle as its trigger.
`define FA_ASSERT_SAME(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
		else $error("assertion failed");

// Checks that a consequent holds in the cycle after its trigger.
`define FA_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/fadd_pkg.sv
// Package for the float32 adder: payload word types and field constants.
// Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package fadd_pkg;
	localparam int ExpW  = 8;
	localparam int FracW = 23;
	localparam int MantW = FracW + 1;
	localparam logic [ExpW-1:0] ExpMax = 8'hFF;

	typedef struct packed {
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} fadd_in_t;

	typedef struct packed {
		logic [31:0] sum_bits;
		logic        overflowed;
	} fadd_out_t;
endpackage
`default_nettype wire

FILE: hw/rtl/fadd_align.sv
// Alignment and magnitude add/subtract stage of the float32 adder.
// Depends on fadd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fadd_align (
	input  wire fadd_pkg::fadd_in_t din,
	output logic [24:0] mant,
	output logic [8:0]  expo,
	output logic        sign,
	output logic        pass,
	output logic [31:0] pass_bits
);
	import fadd_pkg::*;

	logic sa, sb;
	logic [7:0] ea, eb, gap;
	logic [23:0] ma, mb, sh;
	logic a_big;

	always_comb begin
		sa = din.operand_a[31];
		sb = din.operand_b[31];
		ea = din.operand_a[30:23];
		eb = din.operand_b[30:23];
		ma = {1'b1, din.operand_a[22:0]};
		mb = {1'b1, din.operand_b[22:0]};
		a_big = (ea >= eb);
		gap = a_big ? (ea - eb) : (eb - ea);
		sh = a_big ? mb : ma;
		sh = (gap >= 8'd24) ? 24'd0 : (sh >> gap[4:0]);
		if (a_big) mb = sh; else ma = sh;
		expo = {1'b0, a_big ? ea : eb};
		pass = 1'b1;
		pass_bits = 32'd0;
		if (ea == 8'd0 && eb != 8'd0) pass_bits = din.operand_b;
		else if (eb == 8'd0 && ea != 8'd0) pass_bits = din.operand_a;
		else if (ea != 8'd0) pass = 1'b0;
		if (sa == sb) begin
			sign = sa;
			mant = {1'b0, ma} + {1'b0, mb};
		end else if (ma > mb) begin
			sign = sa;
			mant = {1'b0, ma - mb};
		end else if (mb > ma) begin
			sign = sb;
			mant = {1'b0, mb - ma};
		end else begin
			sign = 1'b0;
			mant = 25'd0;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/fadd_norm.sv
// Normalization and packing stage of the float32 adder.
// Depends on fadd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fadd_norm (
	input  wire [24:0] mant,
	input  wire [8:0]  expo,
	input  wire        sign,
	input  wire        pass,
	input  wire [31:0] pass_bits,
	output fadd_pkg::fadd_out_t dout
);
	import fadd_pkg::*;

	logic [23:0] m;
	logic [9:0]  e;
	logic [4:0]  lz;
	logic        found;

	always_comb begin
		m = mant[24] ? mant[24:1] : mant[23:0];
		e = {1'b0, expo} + (mant[24] ? 10'd1 : 10'd0);
		// Leading-zero count over the 24-bit magnitude (priority search).
		lz = 5'd0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && m[i]) begin
				lz = 5'(23 - i);
				found = 1'b1;
			end
		end
		m = m << lz;
		e = e - {5'd0, lz};
		dout = '0;
		if (pass) begin
			dout.sum_bits = pass_bits;
		end else if (mant == 25'd0) begin
			dout.sum_bits = 32'd0;
		end else if (!e[9] && e >= 10'd255) begin
			dout.sum_bits = {sign, ExpMax, 23'd0};
			dout.overflowed = 1'b1;
		end else if (e[9] || e == 10'd0) begin
			dout.sum_bits = 32'd0;
		end else begin
			dout.sum_bits = {sign, e[7:0], m[22:0]};
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/float32_adder_top.sv
// Top level of the float32 adder: input register, datapath, result register.
// Depends on fadd_pkg, fadd_align, fadd_norm and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
// Truncating single-precision adder. One operand word is taken in every
// cycle (busy stays low); its result word passes the input register and the
// result register and appears on result with strobe high for one cycle only,
// since the receiver cannot stall. These registers sit around one
// combinational align/add/normalize pass.
module float32_adder_top (
	input  wire clk,
	input  wire arst_n,
	input  wire start,
	output logic busy,
	input  wire fadd_pkg::fadd_in_t operands,
	output logic strobe,
	output fadd_pkg::fadd_out_t result
);
	import fadd_pkg::*;
	`include "float32_adder_top_assert.svh"

	fadd_in_t  din_s1;
	logic      vld_s1, vld_s2;
	fadd_out_t res_s2, nxt;
	logic [24:0] mant;
	logic [8:0]  expo;
	logic sign, pass;
	logic [31:0] pass_bits;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) din_s1 <= operands;
		if (vld_s1) res_s2 <= nxt;
	end

	fadd_align u_align (.din(din_s1), .mant(mant), .expo(expo), .sign(sign),
		.pass(pass), .pass_bits(pass_bits));
	fadd_norm u_norm (.mant(mant), .expo(expo), .sign(sign), .pass(pass),
		.pass_bits(pass_bits), .dout(nxt));

	assign strobe = vld_s2;
	assign result = res_s2;

	`FA_ASSERT_NEXT(a_start_flows, clk, arst_n, start, vld_s1)
	`FA_ASSERT_NEXT(a_s1_flows, clk, arst_n, vld_s1, strobe)
	`FA_ASSERT_SAME(a_ovf_inf, clk, arst_n, strobe && result.overflowed,
		result.sum_bits[30:0] == {ExpMax, 23'd0})
endmodule
`default_nettype wire
